FILE: hdl/vgmcse_pkg.sv
// ----------------------------------------------------------------------------
// vgmcse_pkg
// Types, codes and constants shared by the VGM command stream encoder.
// ----------------------------------------------------------------------------
package vgmcse_pkg;

  // Upper limit on the number of full-length waits in one flush.
  localparam int unsigned MaxFullWaits = 62;

  localparam int unsigned PendW    = 26;
  localparam int unsigned SampW    = 22;
  localparam int unsigned CountW   = 32;

  localparam logic [SampW-1:0] FullWait = SampW'(65535);
  localparam longint unsigned PendCapL =
    (longint'(MaxFullWaits) + 64'd1) * 64'd65535 * 64'd10 - 64'd1;
  localparam logic [PendW-1:0] PendCap  = PendW'(PendCapL);
  localparam logic [PendW-1:0] FlushMin = PendW'(20);

  // ceil(2^31 / 10); exact quotient for every pending value below 2^26.
  localparam int unsigned      Div10MulW   = 28;
  localparam int unsigned      Div10Shift  = 31;
  localparam logic [Div10MulW-1:0] Div10Mul = 28'hCCCCCCD;
  localparam int unsigned      ProdW       = PendW + Div10MulW;

  localparam logic [7:0]  OpWait     = 8'h61;
  localparam logic [7:0]  OpShortW   = 8'h70;
  localparam logic [7:0]  OpWide     = 8'hE1;
  localparam logic [7:0]  OpNarrow   = 8'h54;
  localparam logic [7:0]  OpEnd      = 8'h66;
  localparam logic [4:0]  ShortMax   = 5'd16;
  localparam logic [CountW-1:0] LoopBase = 32'h0000_00E4;

  typedef enum logic [1:0] {
    ACT_DELAY = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LOOP  = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_WAIT  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOOP  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] delay_tenths;
    logic [7:0]  chip_command;
    logic [7:0]  port_num;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  byte_len;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [7:0]  byte_d;
    logic [7:0]  byte_e;
    logic [31:0] total_samples;
    logic [31:0] loop_samples;
    logic [31:0] loop_offset;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_delay;
    logic load_item;
    logic do_mul;
    logic do_split;
    logic do_acct;
    logic emit_full;
    logic emit_rem;
    logic emit_rec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush_needed;
    logic full_left;
    logic rem_nonzero;
    logic slot_free;
  } dp_status_t;

endpackage

FILE: hdl/vgmcse_ctrl.sv
// ----------------------------------------------------------------------------
// vgmcse_ctrl
// Sequencer for the encoder: takes one item, runs the flush and emits records.
// ----------------------------------------------------------------------------
module vgmcse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_action_i,
  output logic                  in_stall_o,
  input  vgmcse_pkg::dp_status_t status_i,
  output vgmcse_pkg::dp_cmd_t    cmd_o
);
  import vgmcse_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_DIV   = 7'b000_0010,
    S_SPLIT = 7'b000_0100,
    S_ACCT  = 7'b000_1000,
    S_FULL  = 7'b001_0000,
    S_REM   = 7'b010_0000,
    S_REC   = 7'b100_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_DELAY) begin
            cmd_o.acc_delay = 1'b1;
          end else begin
            cmd_o.load_item = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.do_mul = 1'b1;
        state_d      = status_i.flush_needed ? S_SPLIT : S_REC;
      end
      S_SPLIT: begin
        cmd_o.do_split = 1'b1;
        state_d        = S_ACCT;
      end
      S_ACCT: begin
        cmd_o.do_acct = 1'b1;
        state_d       = S_FULL;
      end
      S_FULL: begin
        if (status_i.full_left) begin
          cmd_o.emit_full = status_i.slot_free;
        end else begin
          state_d = S_REM;
        end
      end
      S_REM: begin
        if (status_i.rem_nonzero) begin
          if (status_i.slot_free) begin
            cmd_o.emit_rem = 1'b1;
            state_d        = S_REC;
          end
        end else begin
          state_d = S_REC;
        end
      end
      S_REC: begin
        if (status_i.slot_free) begin
          cmd_o.emit_rec = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/vgmcse_dpath.sv
// ----------------------------------------------------------------------------
// vgmcse_dpath
// Encoder datapath: pending time, counters, divide by ten, record builder and
// the output register.
// ----------------------------------------------------------------------------
module vgmcse_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vgmcse_pkg::in_item_t   in_data_i,
  input  vgmcse_pkg::dp_cmd_t    cmd_i,
  output vgmcse_pkg::dp_status_t status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output vgmcse_pkg::out_item_t  out_data_o
);
  import vgmcse_pkg::*;

  logic [PendW-1:0]  pend_q, pend_d;
  logic [CountW-1:0] samp_cnt_q, samp_cnt_d;
  logic [CountW-1:0] loop_start_q, loop_start_d;
  logic [CountW-1:0] bytes_q, bytes_d;
  logic              out_valid_q, out_valid_d;

  in_item_t          item_q;
  logic [ProdW-1:0]  prod_q;
  logic [SampW-1:0]  samp_q;
  out_item_t         out_q;

  logic [32:0]       delay_sum;
  logic [PendW-1:0]  ten_x;
  logic [PendW-1:0]  samp_ext;
  out_item_t         rec;
  logic              emit;
  logic [15:0]       rem16;

  assign status_o.flush_needed = (pend_q >= FlushMin);
  assign status_o.full_left    = (samp_q >= FullWait);
  assign status_o.rem_nonzero  = (samp_q != '0);
  assign status_o.slot_free    = !out_valid_q || !out_stall_i;

  assign delay_sum = {7'd0, pend_q} + {1'b0, in_data_i.delay_tenths};
  assign samp_ext  = PendW'(samp_q);
  assign ten_x     = (samp_ext << 3) + (samp_ext << 1);
  assign rem16     = samp_q[15:0];
  assign emit      = cmd_i.emit_full || cmd_i.emit_rem || cmd_i.emit_rec;

  // Record builder.
  always_comb begin
    rec = '0;
    if (cmd_i.emit_full) begin
      rec.kind     = KIND_WAIT;
      rec.byte_len = 3'd3;
      rec.byte_a   = OpWait;
      rec.byte_b   = 8'hFF;
      rec.byte_c   = 8'hFF;
    end else if (cmd_i.emit_rem) begin
      rec.kind = KIND_WAIT;
      if (samp_q > SampW'(ShortMax)) begin
        rec.byte_len = 3'd3;
        rec.byte_a   = OpWait;
        rec.byte_b   = rem16[7:0];
        rec.byte_c   = rem16[15:8];
      end else begin
        rec.byte_len = 3'd1;
        rec.byte_a   = OpShortW + rem16[7:0] - 8'd1;
      end
    end else begin
      rec.last = 1'b1;
      case (item_q.action)
        ACT_WRITE: begin
          rec.kind   = KIND_WRITE;
          rec.byte_a = item_q.chip_command;
          if (item_q.chip_command == OpWide) begin
            rec.byte_len = 3'd5;
            rec.byte_b   = item_q.reg_addr[15:8];
            rec.byte_c   = item_q.reg_addr[7:0];
            rec.byte_d   = item_q.reg_value[15:8];
            rec.byte_e   = item_q.reg_value[7:0];
          end else if (item_q.chip_command == OpNarrow) begin
            rec.byte_len = 3'd3;
            rec.byte_b   = item_q.reg_addr[7:0];
            rec.byte_c   = item_q.reg_value[7:0];
          end else begin
            rec.byte_len = 3'd4;
            rec.byte_b   = item_q.port_num;
            rec.byte_c   = item_q.reg_addr[7:0];
            rec.byte_d   = item_q.reg_value[7:0];
          end
        end
        ACT_LOOP: begin
          rec.kind        = KIND_LOOP;
          rec.loop_offset = bytes_q + LoopBase;
        end
        ACT_STOP: begin
          rec.kind          = KIND_END;
          rec.byte_len      = 3'd1;
          rec.byte_a        = OpEnd;
          rec.total_samples = samp_cnt_q;
          rec.loop_samples  = (loop_start_q != '0) ? samp_cnt_q - loop_start_q : '0;
        end
        default: begin
          rec.kind = KIND_WAIT;
        end
      endcase
    end
  end

  always_comb begin
    pend_d       = pend_q;
    samp_cnt_d   = samp_cnt_q;
    loop_start_d = loop_start_q;
    bytes_d      = bytes_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cmd_i.acc_delay) begin
      pend_d = (delay_sum > {7'd0, PendCap}) ? PendCap : delay_sum[PendW-1:0];
    end
    if (cmd_i.do_acct) begin
      samp_cnt_d = samp_cnt_q + CountW'(samp_q);
      // A stop that flushes drops the leftover tenths.
      pend_d     = (item_q.action == ACT_STOP) ? '0 : pend_q - ten_x;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      bytes_d     = bytes_q + CountW'(rec.byte_len);
    end
    if (cmd_i.emit_rec && (item_q.action == ACT_LOOP)) begin
      loop_start_d = samp_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      samp_cnt_q   <= '0;
      loop_start_q <= '0;
      bytes_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_q       <= pend_d;
      samp_cnt_q   <= samp_cnt_d;
      loop_start_q <= loop_start_d;
      bytes_q      <= bytes_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.do_mul) begin
      prod_q <= ProdW'(pend_q) * ProdW'(Div10Mul);
    end
    if (cmd_i.do_split) begin
      samp_q <= prod_q[Div10Shift +: SampW];
    end else if (cmd_i.emit_full) begin
      samp_q <= samp_q - FullWait;
    end
    if (emit) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/vgm_command_stream_encoder.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_encoder
// Turns delays, sound-chip register writes, loop marks and stops into VGM
// command records, one record per output word.
// ----------------------------------------------------------------------------
// A delay word is absorbed and produces nothing. A write, loop mark or stop
// goes from IDLE through DIV to REC, which emits its record, when no wait is
// flushed; with a flush it passes DIV, SPLIT, ACCT, FULL and REM before REC,
// and FULL sends each full 65535-sample wait (at most 62), the waits leaving
// one per cycle from the single output register while the output does not
// stall. The rate is set by the sequencer, which handles one word at a time
// and shares one divide-by-ten multiplier and one wait counter.
module vgm_command_stream_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vgmcse_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vgmcse_pkg::out_item_t out_data_o
);
  import vgmcse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vgmcse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vgmcse_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VGM command stream encoder. A tracker class
// predicts the records that each accepted input word causes and checks every
// output word against the oldest prediction. Directed words cover the record
// formats, flush boundaries and saturation; random words follow, with bursty
// input and patterned output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import vgmcse_pkg::*;

  localparam longint unsigned FullSamples = 65535;
  localparam longint unsigned TenthsCap   =
    (longint'(MaxFullWaits) + 1) * FullSamples * 10 - 1;
  localparam int unsigned RandWords   = 103;

  class vgm_record_tracker;
    out_item_t       due_records[$];
    logic [25:0]     tenths_held;
    logic [31:0]     samples_out;
    logic [31:0]     loop_mark;
    logic [31:0]     bytes_out;
    int unsigned     n_words;
    int unsigned     n_checked;
    int unsigned     n_errors;
    int unsigned     n_kind[4];

    function new();
      tenths_held = '0;
      samples_out = '0;
      loop_mark   = '0;
      bytes_out   = '0;
      n_words     = 0;
      n_checked   = 0;
      n_errors    = 0;
      foreach (n_kind[k]) n_kind[k] = 0;
    endfunction

    function void queue_record(out_item_t r);
      bytes_out = bytes_out + 32'(r.byte_len);
      due_records.push_back(r);
    endfunction

    // Emits the wait records for the whole samples held, if at least two.
    function bit flush_waits();
      longint unsigned samples;
      longint unsigned full;
      longint unsigned rest;
      out_item_t       r;
      if (tenths_held < 26'd20) return 1'b0;
      samples     = longint'(tenths_held) / 10;
      samples_out = samples_out + samples[31:0];
      full        = samples / FullSamples;
      rest        = samples % FullSamples;
      repeat (full) begin
        r        = '0;
        r.kind   = KIND_WAIT;
        r.byte_len = 3'd3;
        r.byte_a = OpWait;
        r.byte_b = 8'hFF;
        r.byte_c = 8'hFF;
        queue_record(r);
      end
      r      = '0;
      r.kind = KIND_WAIT;
      if (rest > 16) begin
        r.byte_len = 3'd3;
        r.byte_a   = OpWait;
        r.byte_b   = rest[7:0];
        r.byte_c   = rest[15:8];
        queue_record(r);
      end else if (rest > 0) begin
        r.byte_len = 3'd1;
        r.byte_a   = OpShortW + 8'(rest - 1);
        queue_record(r);
      end
      tenths_held = tenths_held % 26'd10;
      return 1'b1;
    endfunction

    function void note_word(in_item_t w);
      longint unsigned sum;
      out_item_t       r;
      n_words++;
      r      = '0;
      r.last = 1'b1;
      case (action_e'(w.action))
        ACT_DELAY: begin
          sum = longint'(tenths_held) + longint'(w.delay_tenths);
          tenths_held = (sum > TenthsCap) ? 26'(TenthsCap) : 26'(sum);
        end
        ACT_WRITE: begin
          void'(flush_waits());
          r.kind   = KIND_WRITE;
          r.byte_a = w.chip_command;
          if (w.chip_command == OpWide) begin
            r.byte_len = 3'd5;
            r.byte_b   = w.reg_addr[15:8];
            r.byte_c   = w.reg_addr[7:0];
            r.byte_d   = w.reg_value[15:8];
            r.byte_e   = w.reg_value[7:0];
          end else if (w.chip_command == OpNarrow) begin
            r.byte_len = 3'd3;
            r.byte_b   = w.reg_addr[7:0];
            r.byte_c   = w.reg_value[7:0];
          end else begin
            r.byte_len = 3'd4;
            r.byte_b   = w.port_num;
            r.byte_c   = w.reg_addr[7:0];
            r.byte_d   = w.reg_value[7:0];
          end
          queue_record(r);
        end
        ACT_LOOP: begin
          void'(flush_waits());
          loop_mark     = samples_out;
          r.kind        = KIND_LOOP;
          r.loop_offset = bytes_out + LoopBase;
          queue_record(r);
        end
        default: begin
          // A stop that flushes drops the leftover tenths as well.
          if (flush_waits()) tenths_held = '0;
          r.kind          = KIND_END;
          r.byte_len      = 3'd1;
          r.byte_a        = OpEnd;
          r.total_samples = samples_out;
          r.loop_samples  = (loop_mark != '0) ? samples_out - loop_mark : '0;
          queue_record(r);
        end
      endcase
    endfunction

    function void cmp_field(string fname, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
        n_errors++;
      end
    endfunction

    function void check_record(out_item_t got);
      out_item_t want;
      if (due_records.size() == 0) begin
        $error("record with nothing predicted: 0x%0h", got);
        n_errors++;
        return;
      end
      want = due_records.pop_front();
      n_checked++;
      n_kind[want.kind]++;
      cmp_field("kind", want.kind, got.kind);
      cmp_field("byte_len", want.byte_len, got.byte_len);
      cmp_field("byte_a", want.byte_a, got.byte_a);
      cmp_field("byte_b", want.byte_b, got.byte_b);
      cmp_field("byte_c", want.byte_c, got.byte_c);
      cmp_field("byte_d", want.byte_d, got.byte_d);
      cmp_field("byte_e", want.byte_e, got.byte_e);
      cmp_field("total_samples", want.total_samples, got.total_samples);
      cmp_field("loop_samples", want.loop_samples, got.loop_samples);
      cmp_field("loop_offset", want.loop_offset, got.loop_offset);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  vgm_record_tracker tracker = new();
  int unsigned       burst_left = 0;

  always #5 clk = ~clk;

  vgm_command_stream_encoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Output side: the stall pattern is one of four modes, drawn anew when mode_age
  // runs out; records are checked on the edge at which they are taken.
  int unsigned stall_mode = 0;
  int unsigned mode_age   = 0;
  int unsigned stall_run  = 0;
  always @(posedge clk) begin
    logic next_stall;
    if (rst_ni && out_valid && !out_stall) tracker.check_record(out_data);
    if (mode_age == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_age   = 256;
    end
    mode_age--;
    case (stall_mode)
      0: next_stall = 1'b0;
      1: next_stall = ($urandom_range(0, 3) == 0);
      2: next_stall = ($urandom_range(0, 9) < 6);
      default: begin
        if (stall_run == 0) stall_run = $urandom_range(1, 16);
        stall_run--;
        next_stall = (stall_run < 8) ? 1'b0 : 1'b1;
      end
    endcase
    out_stall <= next_stall;
  end

  function automatic in_item_t make_word(action_e act, logic [31:0] delay, logic [7:0] cmd,
                                         logic [7:0] port, logic [15:0] addr,
                                         logic [15:0] value);
    in_item_t w;
    w.action       = act;
    w.delay_tenths = delay;
    w.chip_command = cmd;
    w.port_num     = port;
    w.reg_addr     = addr;
    w.reg_value    = value;
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t    w;
    int unsigned pick;
    w.delay_tenths = $urandom();
    w.port_num     = 8'($urandom_range(0, 255));
    w.reg_addr     = 16'($urandom_range(0, 65535));
    w.reg_value    = 16'($urandom_range(0, 65535));
    pick           = $urandom_range(0, 3);
    w.chip_command = (pick == 0) ? OpWide : (pick == 1) ? OpNarrow : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) w.action = ACT_DELAY;
    else if (pick < 80) w.action = ACT_WRITE;
    else if (pick < 90) w.action = ACT_LOOP;
    else w.action = ACT_STOP;
    if (w.action == ACT_DELAY) begin
      pick = $urandom_range(0, 99);
      // Mostly short delays; a few long enough for full waits or saturation.
      if (pick < 40) w.delay_tenths = $urandom_range(0, 40);
      else if (pick < 75) w.delay_tenths = $urandom_range(0, 2000);
      else if (pick < 93) w.delay_tenths = $urandom_range(0, 700000);
    end
    return w;
  endfunction

  // Sends one word, opening a new burst after a random gap when one ends.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
  endtask

  task automatic drain_records();
    in_valid <= 1'b0;
    while (tracker.due_records.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Stop and loop mark while the loop start is still zero.
    send_word(make_word(ACT_STOP, '1, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_LOOP, '0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    // The three write record formats, the wide and default ones at the extremes of their fields.
    send_word(make_word(ACT_WRITE, '0, OpWide, 8'h00, 16'hFFFF, 16'hFFFF));
    send_word(make_word(ACT_WRITE, '1, OpWide, 8'hFF, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, OpNarrow, 8'h5A, 16'hA5AB, 16'h12CD));
    send_word(make_word(ACT_WRITE, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    // Nineteen tenths stay put; twenty flush as two samples.
    send_word(make_word(ACT_DELAY, 32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_DELAY, 32'd19, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, 8'h52, 8'h01, 16'h0028, 16'h00F0));
    send_word(make_word(ACT_DELAY, 32'd1, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, 8'h52, 8'h00, 16'h0030, 16'h0011));
    // Seventeen samples need the 16-bit wait, sixteen the short one.
    send_word(make_word(ACT_DELAY, 32'd175, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_LOOP, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_DELAY, 32'd155, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, OpNarrow, 8'h00, 16'h0001, 16'h0002));
    // Exactly one full wait with no remainder.
    send_word(make_word(ACT_DELAY, 32'd655350, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, OpWide, 8'h00, 16'h1234, 16'h5678));
    // Saturated accumulator, then a stop that flushes and clears.
    send_word(make_word(ACT_DELAY, '1, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_DELAY, 32'd5, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_STOP, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    // A stop without a flush keeps its tenths for the next write.
    send_word(make_word(ACT_DELAY, 32'd15, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_STOP, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_DELAY, 32'd10, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_WRITE, '0, 8'hA0, 8'h02, 16'h0040, 16'h007F));
    // A loop mark after a flush, then a stop that reports the loop length.
    send_word(make_word(ACT_LOOP, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    send_word(make_word(ACT_STOP, '0, 8'h00, 8'h00, 16'h0000, 16'h0000));

    for (int unsigned i = 0; i < RandWords; i++) begin
      if (i == RandWords / 2) drain_records();
      send_word(random_word());
    end

    drain_records();
    repeat (100) @(posedge clk);
    if (tracker.due_records.size() != 0) begin
      $error("%0d predicted records never arrived", tracker.due_records.size());
      tracker.n_errors++;
    end
    $display("Sent %0d input words; checked %0d records: %0d waits, %0d writes,",
             tracker.n_words, tracker.n_checked, tracker.n_kind[KIND_WAIT],
             tracker.n_kind[KIND_WRITE]);
    $display("%0d loop marks and %0d end records, under bursty input and output stalls.",
             tracker.n_kind[KIND_LOOP], tracker.n_kind[KIND_END]);
    if (tracker.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Run timed out with %0d records outstanding.", tracker.due_records.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
